FILE: src/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int CNT_W    = (CNT_BITS > 5) ? CNT_BITS : 5;
	localparam int OCC_W    = 5;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef struct packed {
		logic               func;
		logic signed [31:0] item_value;
		logic signed [31:0] item_weight;
	} cmd_t;

	typedef struct packed {
		logic               got_valid;
		logic signed [31:0] got_value;
		logic signed [31:0] got_weight;
		logic               dropped;
		logic [OCC_W-1:0]   occupancy;
	} result_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] weight;
	} entry_t;

	// operation broadcast combinationally to every cell
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t entry;
	} cell_ctl_t;

endpackage

FILE: src/sorted_priority_queue.sv
// Sorted priority queue, CAPACITY value/weight pairs kept in ascending
// signed weight order, equal weights in arrival order.
// Command channel: a word on cmd is taken at a rising edge with start
// high and busy low. busy stays low: one command is taken every cycle.
// func enqueue inserts the pair behind every entry of equal or smaller
// weight, or drops it and flags dropped when the queue is full. func
// dequeue removes the head and returns its value and weight with
// got_valid set; on an empty queue it returns zeros.
// Result channel: one result word per command, on result for exactly one
// cycle with done high, in the cycle after the command was taken
// (throughput 1 word per cycle). The receiver cannot stall;
// a result not taken in its cycle is gone.
// Storage is a row of cells, one per slot; every cell compares its own
// weight with the incoming one in parallel, and each one shifts from its
// left or right neighbor, so the whole row inserts or removes together.
// Reset clears the entry count and done; slot contents are left as is
// and are never read before they are written.
module sorted_priority_queue import spq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	result_t          result_q;

	logic      take;
	logic      full;
	logic      empty;
	cell_ctl_t ctl;

	logic   [CAPACITY-1:0] occ;
	logic   [CAPACITY-1:0] mv;
	entry_t [CAPACITY-1:0] cell_entry;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// broadcast the operation; suppress it when it cannot change the row
	assign ctl.enq   = take && (cmd.func == FUNC_ENQ) && !full;
	assign ctl.deq   = take && (cmd.func == FUNC_DEQ) && !empty;
	assign ctl.entry = '{value: cmd.item_value, weight: cmd.item_weight};

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			logic   left_m;

			// slots below the count are held
			assign occ[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign left_m = 1'b0;
				assign left_e = ctl.entry;
			end else begin : g_body
				assign left_m = mv[gi-1];
				assign left_e = cell_entry[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign right_e = cell_entry[gi];
			end else begin : g_inner
				assign right_e = cell_entry[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[gi]),
				.left_mv     (left_m),
				.left_entry  (left_e),
				.right_entry (right_e),
				.mv          (mv[gi]),
				.entry       (cell_entry[gi])
			);
		end
	endgenerate

	// advance the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (ctl.enq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.deq) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// build the result word from the head cell and the count after the op
	always_ff @(posedge clk) begin
		if (take) begin
			result_q.got_valid  <= ctl.deq;
			result_q.got_value  <= ctl.deq ? cell_entry[0].value : '0;
			result_q.got_weight <= ctl.deq ? cell_entry[0].weight : '0;
			result_q.dropped    <= (cmd.func == FUNC_ENQ) && full;
			if (ctl.enq) begin
				result_q.occupancy <= OCC_W'(count_q + CNT_W'(1));
			end else if (ctl.deq) begin
				result_q.occupancy <= OCC_W'(count_q - CNT_W'(1));
			end else begin
				result_q.occupancy <= OCC_W'(count_q);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: src/spq_cell.sv
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occ,
	input  logic      left_mv,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	output logic      mv,
	output entry_t    entry
);

	entry_t entry_q;

	// new word lands at or before this slot
	assign mv    = !occ || (entry_q.weight > ctl.entry.weight);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (left_mv) begin
				entry_q <= left_entry;
			end else if (mv) begin
				entry_q <= ctl.entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: verif/tb_top.sv
module tb_top import spq_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with neither a command taken nor a result seen before giving up
	localparam int WATCHDOG_LIMIT = 1000;
	// settle time after the last result
	localparam int TAIL_CYCLES    = 8;
	// random command words per idling phase, four phases
	localparam int PHASE_WORDS    = 470;

	// one line of the directed script: a command word repeated reps times,
	// value bumped by one per repeat; pinned rows carry a hand-written result
	typedef struct {
		cmd_t    word;
		int      reps;
		bit      pinned;
		result_t want;
	} script_row_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	// pinned expectation travels with the command word it belongs to
	bit      pin_flag = 1'b0;
	result_t pin_res  = '0;

	// shadow copy of the queue contents, slot 0 is the head
	logic signed [31:0] slot_value  [CAPACITY];
	logic signed [31:0] slot_weight [CAPACITY];
	int                 held = 0;

	result_t due_results [$];
	int      mismatches  = 0;
	int      quiet_cycles = 0;

	sorted_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one command to the shadow queue and return the result word it
	// must produce. Ties: a new entry goes behind every entry whose weight
	// is equal or smaller, so equal weights leave in arrival order.
	function automatic result_t shadow_queue_op(cmd_t c);
		result_t r;
		int      pos;
		int      i;
		r = '0;
		if (c.func == FUNC_ENQ) begin
			if (held >= CAPACITY) begin
				// full: drop the pair, leave the contents alone
				r.dropped = 1'b1;
			end else begin
				pos = 0;
				while (pos < held && $signed(slot_weight[pos]) <= $signed(c.item_weight))
					pos++;
				for (i = held; i > pos; i--) begin
					slot_value[i]  = slot_value[i-1];
					slot_weight[i] = slot_weight[i-1];
				end
				slot_value[pos]  = c.item_value;
				slot_weight[pos] = c.item_weight;
				held++;
			end
		end else if (held > 0) begin
			// pop the head, shift the rest one slot forward
			r.got_valid  = 1'b1;
			r.got_value  = slot_value[0];
			r.got_weight = slot_weight[0];
			for (i = 1; i < held; i++) begin
				slot_value[i-1]  = slot_value[i];
				slot_weight[i-1] = slot_weight[i];
			end
			held--;
		end
		// an empty dequeue leaves everything zero
		r.occupancy = OCC_W'(held);
		return r;
	endfunction

	task automatic note_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Score every result word against the oldest expectation, then log the
	// command taken at this edge. The DUT answers in the next cycle, so a word
	// pushed here is never the one popped at the same edge.
	always @(posedge clk) begin : scoreboard
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result word with nothing expected, occupancy %0d",
							result.occupancy);
				end else begin
					want = due_results.pop_front();
					note_field("got_valid",  want.got_valid,  result.got_valid);
					note_field("got_value",  want.got_value,  result.got_value);
					note_field("got_weight", want.got_weight, result.got_weight);
					note_field("dropped",    want.dropped,    result.dropped);
					note_field("occupancy",  want.occupancy,  result.occupancy);
				end
			end
			if (start && !busy) begin
				// keep the shadow in step even when the row pins its own result
				want = shadow_queue_op(cmd);
				due_results.push_back(pin_flag ? pin_res : want);
			end
			// watchdog: count cycles with no traffic in either direction
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Present one command word from a falling edge and hold it until taken.
	// Idle first with the given chance per cycle; start gets exactly one
	// assignment per falling edge.
	task automatic send_word(cmd_t w, bit pin, result_t want, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		cmd      <= w;
		pin_flag <= pin;
		pin_res  <= want;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Hold the sender off until every expected result word has come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	// Random command word. Weights mix a narrow band (many ties), the signed
	// extremes around zero, and full-range patterns; dequeue words still
	// carry random fields, which the block must ignore.
	function automatic cmd_t random_word(int enq_pct);
		cmd_t c;
		c.func       = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
		c.item_value = $urandom;
		case ($urandom_range(3))
			0: begin
				c.item_weight = $signed($urandom_range(8)) - 4;
			end
			1: begin
				case ($urandom_range(3))
					0: c.item_weight = 32'sh8000_0000;
					1: c.item_weight = 32'sh7fff_ffff;
					2: c.item_weight = 32'sh0000_0000;
					default: c.item_weight = 32'shffff_ffff;
				endcase
			end
			default: begin
				c.item_weight = $urandom;
			end
		endcase
		return c;
	endfunction

	initial begin : stimulus
		script_row_t script [$];
		script_row_t row;
		cmd_t        w;
		int          phase_idle [4];
		int          sent;
		int          burst;
		int          enq_pct;
		result_t     none;

		none = '0;
		phase_idle = '{0, 56, 0, 23};

		// empty dequeue, with and without junk in the ignored fields
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b1,
			result_t'{1'b0, 32'sd0, 32'sd0, 1'b0, 5'd0}});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sh7fff_ffff, 32'sh8000_0000}, 1, 1'b1,
			result_t'{1'b0, 32'sd0, 32'sd0, 1'b0, 5'd0}});
		// signed extremes in, smallest weight must come out first
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1, 1'b1,
			result_t'{1'b0, 32'sd0, 32'sd0, 1'b0, 5'd1}});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sh8000_0000, 32'sh8000_0000}, 1, 1'b1,
			result_t'{1'b0, 32'sd0, 32'sd0, 1'b0, 5'd2}});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'shffff_ffff, 32'sd0}, 1, 1'b1,
			result_t'{1'b0, 32'sd0, 32'sd0, 1'b0, 5'd3}});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b1,
			result_t'{1'b1, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 5'd2}});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b1,
			result_t'{1'b1, 32'shffff_ffff, 32'sd0, 1'b0, 5'd1}});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b1,
			result_t'{1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 5'd0}});
		// equal weights must leave in arrival order, a smaller one jumps ahead
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sd1, 32'sd5}, 1, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sd2, 32'sd5}, 1, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sd3, -32'sd1}, 1, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sd4, 32'sd5}, 1, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sd5, 32'sh8000_0000}, 1, 1'b0, none});
		// fill to the brim at the largest weight, then overflow once
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sd100, 32'sh7fff_ffff}, 13, 1'b0, none});
		script.push_back('{cmd_t'{FUNC_ENQ, 32'sh5555_5555, 32'sd0}, 1, 1'b1,
			result_t'{1'b0, 32'sd0, 32'sd0, 1'b1, 5'd16}});
		script.push_back('{cmd_t'{FUNC_DEQ, 32'sd0, 32'sd0}, 1, 1'b0, none});

		// hold reset, then release it on a falling edge
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed script, back to back
		foreach (script[r]) begin
			row = script[r];
			for (int k = 0; k < row.reps; k++) begin
				w = row.word;
				w.item_value = row.word.item_value + k;
				send_word(w, row.pinned, row.want, 0);
			end
		end

		// Random part. Each phase starts from a drained pipe, then runs bursts
		// that lean toward enqueue (fill, hit full, drop), toward dequeue
		// (drain, pop empty) or stay balanced around mid occupancy.
		foreach (phase_idle[p]) begin
			wait_drained();
			sent = 0;
			while (sent < PHASE_WORDS) begin
				burst = $urandom_range(10, 60);
				case ($urandom_range(2))
					0: enq_pct = 85;
					1: enq_pct = 50;
					default: enq_pct = 15;
				endcase
				repeat (burst) begin
					send_word(random_word(enq_pct), 1'b0, none, phase_idle[p]);
					sent++;
				end
			end
		end

		// drop start, let the last words come home, then a short tail so
		// any stray result word still gets caught
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sorted_priority_queue.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
verif/tb_top.sv
